### rtl/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg
// shared types and constants of the phase current to signed magnitude block
// ----------------------------------------------------------------------------
package pcsm_pkg;

  localparam int CalSamples  = 1024;
  localparam int AdcBits     = 12;
  localparam int AngleBits   = 16;
  localparam int CordicSteps = 20;
  localparam int CalLog2     = $clog2(CalSamples);
  localparam int CntW        = CalLog2 + 1;
  localparam int SumW        = AdcBits + CalLog2;

  localparam logic [1:0] CfgAmpsPerCount = 2'd0;
  localparam logic [1:0] CfgInvertA      = 2'd1;
  localparam logic [1:0] CfgInvertB      = 2'd2;

  localparam logic FuncMeasure = 1'b0;
  localparam logic FuncCal     = 1'b1;

  typedef struct packed {
    logic        func;
    logic [11:0] sample_a;
    logic [11:0] sample_b;
    logic [15:0] elec_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] signed_magnitude;
    logic signed [15:0] phase_a_amps;
    logic signed [15:0] phase_b_amps;
    logic               calibration_done;
    logic               saturated;
  } out_item_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage

### rtl/phase_current_to_signed_magnitude.sv
// ----------------------------------------------------------------------------
// phase_current_to_signed_magnitude
// shunt current scaling, offset calibration and signed vector magnitude
// ----------------------------------------------------------------------------
// channel  direction  payload      handshake
// in_      input      in_item_t    in_valid / in_stall
// out_     output     out_item_t   out_valid / out_stall
// cfg_     input      index, data  cfg_we
// a calibration transaction passes S_CAL and S_OUT; a measure transaction runs
// two scaling products, three square terms and a reciprocal multiply for the
// divide by three on one shared multiplier, 20 square root steps and
// 20 cordic steps one after another
// reset is synchronous; no clearing pass
// the result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
module phase_current_to_signed_magnitude (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcsm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcsm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  import pcsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CAL, S_MULA, S_MULB, S_SQ, S_SQRT, S_ROOT, S_CORD, S_SIGN, S_OUT
  } state_t;

  state_t state_r;
  logic [23:0] apc_r;
  logic inv_a_r, inv_b_r;
  logic [AdcBits-1:0] off_a_r, off_b_r;
  logic [SumW-1:0] sum_a_r, sum_b_r;
  logic [CntW-1:0] cnt_r;
  in_item_t item_r;
  logic sat_r;
  logic signed [15:0] ia_r, ib_r;
  logic [2:0] sq_r;
  logic [35:0] q_r;
  logic [39:0] rt_r;
  logic [4:0] it_r;
  logic signed [63:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [16:0] m_r;
  logic [39:0] prod_r;
  out_item_t out_r;
  logic out_valid_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [AdcBits:0] diff;
  logic diff_neg, inv_sel;
  logic [AdcBits-1:0] d_abs;
  logic [36:0] scl;
  logic signed [37:0] sgn;
  logic signed [15:0] clipped;
  logic clip_sat;

  always_comb begin
    if (state_r == S_MULA) begin
      diff = $signed({1'b0, item_r.sample_a[AdcBits-1:0]}) - $signed({1'b0, off_a_r});
      inv_sel = inv_a_r;
    end else begin
      diff = $signed({1'b0, item_r.sample_b[AdcBits-1:0]}) - $signed({1'b0, off_b_r});
      inv_sel = inv_b_r;
    end
    diff_neg = diff[AdcBits];
    d_abs = diff_neg ? AdcBits'(-diff) : diff[AdcBits-1:0];
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state_r)
      S_MULA, S_MULB: begin
        mul_a = $signed({21'd0, d_abs});
        mul_b = $signed({9'd0, apc_r});
      end
      S_SQ: begin
        case (sq_r)
          3'd0: begin mul_a = 33'(ia_r); mul_b = 33'(ia_r); end
          3'd1: begin mul_a = 33'(ia_r); mul_b = 33'(ib_r); end
          3'd2: begin mul_a = 33'(ib_r); mul_b = 33'(ib_r); end
          3'd3: begin
            mul_a = $signed({1'b0, q_r[31:0]});
            mul_b = $signed({1'b0, 32'hAAAA_AAAB});
          end
          default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
        endcase
      end
      S_ROOT: begin
        mul_a = 33'(ia_r) + 33'(ib_r) + 33'(ib_r);
        mul_b = 33'sd619925131;
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
    scl = (37'(mul_p[35:0]) + 37'd2048) >> 12;
    sgn = (diff_neg != inv_sel) ? -$signed({1'b0, scl}) : $signed({1'b0, scl});
    clip_sat = 1'b0;
    if (sgn > 38'sd32767) begin
      clipped = 16'sd32767; clip_sat = 1'b1;
    end else if (sgn < -38'sd32768) begin
      clipped = -16'sd32768; clip_sat = 1'b1;
    end else begin
      clipped = sgn[15:0];
    end
  end

  // sqrt digit by digit
  logic [39:0] sq_try;
  logic [39:0] sq_bit;
  assign sq_bit = 40'd1 << {it_r, 1'b0};
  assign sq_try = rt_r + sq_bit;

  // cordic
  logic signed [63:0] xs, ys;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  logic [AdcBits-1:0] avg_a, avg_b;
  logic [SumW-1:0] nsum_a, nsum_b;
  logic [SumW:0] rnd_a, rnd_b;
  logic cal_last;
  assign nsum_a = sum_a_r + SumW'(item_r.sample_a[AdcBits-1:0]);
  assign nsum_b = sum_b_r + SumW'(item_r.sample_b[AdcBits-1:0]);
  assign rnd_a = {1'b0, nsum_a} + (SumW+1)'(CalSamples / 2);
  assign rnd_b = {1'b0, nsum_b} + (SumW+1)'(CalSamples / 2);
  assign avg_a = rnd_a[SumW:CalLog2] > (SumW+1-CalLog2)'({AdcBits{1'b1}}) ?
                 {AdcBits{1'b1}} : rnd_a[CalLog2 +: AdcBits];
  assign avg_b = rnd_b[SumW:CalLog2] > (SumW+1-CalLog2)'({AdcBits{1'b1}}) ?
                 {AdcBits{1'b1}} : rnd_b[CalLog2 +: AdcBits];
  assign cal_last = (cnt_r + 1'b1 >= CntW'(CalSamples));

  logic [31:0] ang;
  assign ang = {item_r.elec_angle[AngleBits-1:0], {(32-AngleBits){1'b0}}};

  logic signed [17:0] msign;
  assign msign = -$signed({1'b0, m_r});

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      apc_r <= 24'd27034;
      inv_a_r <= 1'b0;
      inv_b_r <= 1'b1;
      off_a_r <= '0;
      off_b_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgAmpsPerCount: apc_r <= cfg_data;
          CfgInvertA: inv_a_r <= cfg_data[0];
          CfgInvertB: inv_b_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            sat_r <= 1'b0;
            state_r <= (in_data.func == FuncCal) ? S_CAL : S_MULA;
          end
        end
        S_CAL: begin
          out_r <= {48'd0, cal_last, 1'b0};
          if (cal_last) begin
            off_a_r <= avg_a;
            off_b_r <= avg_b;
            sum_a_r <= '0;
            sum_b_r <= '0;
            cnt_r <= '0;
          end else begin
            sum_a_r <= nsum_a;
            sum_b_r <= nsum_b;
            cnt_r <= cnt_r + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_MULA: begin
          ia_r <= clipped;
          sat_r <= clip_sat;
          state_r <= S_MULB;
        end
        S_MULB: begin
          ib_r <= clipped;
          sat_r <= sat_r | clip_sat;
          q_r <= '0;
          sq_r <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          case (sq_r)
            3'd0, 3'd1, 3'd2: q_r <= q_r + 36'(mul_p[35:0]);
            default: ;
          endcase
          // 16q/3 as 5q plus q/3
          if (sq_r == 3'd3) begin
            prod_r <= {2'b00, q_r, 2'b00} + {4'd0, q_r} + {9'd0, mul_p[63:33]};
            it_r <= 5'd19;
            rt_r <= '0;
            state_r <= S_SQRT;
          end
          sq_r <= sq_r + 3'd1;
        end
        S_SQRT: begin
          if (prod_r >= sq_try) begin
            prod_r <= prod_r - sq_try;
            rt_r <= (rt_r >> 1) + sq_bit;
          end else begin
            rt_r <= rt_r >> 1;
          end
          if (it_r == 5'd0) state_r <= S_ROOT;
          it_r <= it_r - 5'd1;
        end
        S_ROOT: begin
          m_r <= 17'((rt_r + 40'd1) >> 1);
          it_r <= '0;
          if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            x_r <= -(64'(ia_r) <<< 30);
            y_r <= -64'(mul_p);
            z_r <= 34'($signed(ang - 32'h8000_0000));
          end else begin
            x_r <= 64'(ia_r) <<< 30;
            y_r <= 64'(mul_p);
            z_r <= 34'($signed(ang));
          end
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (!z_r[33]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r - 34'(atan_turn(it_r));
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r + 34'(atan_turn(it_r));
          end
          if (it_r == 5'(CordicSteps - 1)) state_r <= S_SIGN;
          it_r <= it_r + 5'd1;
        end
        S_SIGN: begin
          out_r.phase_a_amps <= ia_r;
          out_r.phase_b_amps <= ib_r;
          out_r.calibration_done <= 1'b0;
          if (item_r.elec_angle[AngleBits-1:0] == '0 || y_r > 64'sd0) begin
            if (m_r > 17'd32767) begin
              out_r.signed_magnitude <= 16'sd32767;
              out_r.saturated <= 1'b1;
            end else begin
              out_r.signed_magnitude <= m_r[15:0];
              out_r.saturated <= sat_r;
            end
          end else begin
            if (msign < -18'sd32768) begin
              out_r.signed_magnitude <= -16'sd32768;
              out_r.saturated <= 1'b1;
            end else begin
              out_r.signed_magnitude <= msign[15:0];
              out_r.saturated <= sat_r;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### test/phase_current_to_signed_magnitude_tb.sv
// ----------------------------------------------------------------------------
// phase_current_to_signed_magnitude_tb
// drives calibration and measure transactions with random idling on both
// channels, predicts every result from an in-bench model of the scaling,
// offset averaging, magnitude and cordic sign logic, and compares each result
// as one whole struct, in order
// ----------------------------------------------------------------------------
module phase_current_to_signed_magnitude_tb;
  import pcsm_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  phase_current_to_signed_magnitude dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [23:0] gain;
  logic inv_a, inv_b;
  longint off_a, off_b, acc_a, acc_b, cal_cnt;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int mismatches;
  int cycles;
  bit quiet_in, quiet_out;
  int in_idle_pct, out_idle_pct;
  bit drain_hold;

  localparam longint AtanTbl[20] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304};

  function automatic longint clip_q12(longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint scaled_current(longint s, longint off, bit inv, inout bit sat);
    longint d;
    longint q;
    d = s - off;
    q = (((d < 0) ? -d : d) * longint'(gain) + 2048) >>> 12;
    if ((d < 0) != inv) q = -q;
    return clip_q12(q, sat);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit q_axis_positive(longint ia, longint ib, logic [15:0] ang);
    longint x, y, z, xs, ys;
    logic [31:0] a;
    x = ia * 64'sd1073741824;
    y = (ia + 2 * ib) * 64'sd619925131;
    a = {ang, 16'd0};
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      x = -x;
      y = -y;
      a = a - 32'h8000_0000;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z - AtanTbl[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z + AtanTbl[i];
      end
    end
    return y > 0;
  endfunction

  function automatic out_item_t current_vector(in_item_t it);
    out_item_t r;
    bit sat;
    longint ia, ib, q, m, sm;
    r = '0;
    sat = 0;
    if (it.func == FuncCal) begin
      acc_a += it.sample_a;
      acc_b += it.sample_b;
      cal_cnt++;
      if (cal_cnt >= CalSamples) begin
        off_a = (acc_a + CalSamples / 2) / CalSamples;
        off_b = (acc_b + CalSamples / 2) / CalSamples;
        acc_a = 0;
        acc_b = 0;
        cal_cnt = 0;
        r.calibration_done = 1;
      end
      return r;
    end
    ia = scaled_current(it.sample_a, off_a, inv_a, sat);
    ib = scaled_current(it.sample_b, off_b, inv_b, sat);
    q = ia * ia + ia * ib + ib * ib;
    m = (int_sqrt((16 * q) / 3) + 1) / 2;
    if (it.elec_angle == 0 || q_axis_positive(ia, ib, it.elec_angle)) sm = clip_q12(m, sat);
    else sm = clip_q12(-m, sat);
    r.signed_magnitude = sm[15:0];
    r.phase_a_amps = ia[15:0];
    r.phase_b_amps = ib[15:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic in_item_t rand_item(bit cal);
    in_item_t it;
    it.func = cal ? FuncCal : FuncMeasure;
    it.sample_a = $urandom_range(0, 4095);
    it.sample_b = $urandom_range(0, 4095);
    case ($urandom_range(0, 5))
      0: it.elec_angle = 16'd0;
      1: it.elec_angle = {2'($urandom_range(0, 3)), 14'd0};
      default: it.elec_angle = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 9) == 0) it.sample_a = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    if ($urandom_range(0, 9) == 0) it.sample_b = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    return it;
  endfunction

  function automatic in_item_t mk(bit cal, int sa, int sb, int ang);
    in_item_t it;
    it.func = cal ? FuncCal : FuncMeasure;
    it.sample_a = sa;
    it.sample_b = sb;
    it.elec_angle = ang;
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(current_vector(in_data));
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (pending_items.size() > (in_valid && !in_stall ? 0 : 0) && !drain_hold
                   && (quiet_in || $urandom_range(0, 99) >= in_idle_pct)
                   && pending_items.size() != 0) begin
        in_valid <= 1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %p", out_data);
        end else begin
          if (out_data !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_results[0], out_data);
          end
          void'(expected_results.pop_front());
        end
      end
      out_stall <= !quiet_out && ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("phase_current_to_signed_magnitude regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CfgAmpsPerCount: gain = val;
      CfgInvertA: inv_a = val[0];
      default: inv_b = val[0];
    endcase
  endtask

  task automatic calibrate(int ca, int cb, int spread);
    for (int i = 0; i < CalSamples; i++)
      pending_items.push_back(mk(1, ca + $urandom_range(0, spread), cb + $urandom_range(0, spread),
                                 $urandom_range(0, 65535)));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(rand_item($urandom_range(0, 49) == 0));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CfgAmpsPerCount;
    cfg_data = '0;
    cycles = 0;
    mismatches = 0;
    quiet_in = 0;
    quiet_out = 0;
    in_idle_pct = 19;
    out_idle_pct = 19;
    drain_hold = 0;
    gain = 24'd27034;
    inv_a = 0;
    inv_b = 1;
    off_a = 0;
    off_b = 0;
    acc_a = 0;
    acc_b = 0;
    cal_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, zero offsets, angle special cases
    pending_items.push_back(mk(0, 0, 0, 0));
    pending_items.push_back(mk(0, 4095, 4095, 0));
    pending_items.push_back(mk(0, 4095, 0, 16'h4000));
    pending_items.push_back(mk(0, 0, 4095, 16'h8000));
    pending_items.push_back(mk(0, 2048, 2048, 16'hc000));
    pending_items.push_back(mk(0, 100, 3000, 16'hffff));
    pending_items.push_back(mk(0, 4095, 0, 16'h0001));
    pending_items.push_back(mk(0, 0, 0, 16'h1234));
    pending_items.push_back(mk(1, 4095, 0, 16'hffff));
    pending_items.push_back(mk(0, 1, 2, 16'h7fff));
    wait_idle();
    write_reg(CfgAmpsPerCount, 24'hffffff);
    write_reg(CfgInvertA, 1);
    write_reg(CfgInvertB, 0);
    pending_items.push_back(mk(0, 4095, 4095, 16'h2000));
    pending_items.push_back(mk(0, 0, 4095, 16'h0000));
    pending_items.push_back(mk(0, 1, 0, 16'h9000));
    pending_items.push_back(mk(0, 0, 1, 16'h6000));
    wait_idle();
    write_reg(CfgAmpsPerCount, 24'd0);
    pending_items.push_back(mk(0, 4095, 123, 16'h3000));
    pending_items.push_back(mk(0, 0, 4095, 16'hf000));
    wait_idle();

    // full calibration run, fast and with no idling
    write_reg(CfgAmpsPerCount, 24'd27034);
    write_reg(CfgInvertB, 1);
    quiet_in = 1;
    quiet_out = 1;
    calibrate(2040, 2050, 16);
    random_phase(150);
    wait_idle();
    quiet_in = 0;
    quiet_out = 0;

    write_reg(CfgAmpsPerCount, $urandom_range(0, 24'hffffff));
    write_reg(CfgInvertA, $urandom_range(0, 1));
    write_reg(CfgInvertB, $urandom_range(0, 1));
    random_phase(100);
    // sender holds until everything has drained
    while (pending_items.size() > 50) @(posedge clk);
    drain_hold = 1;
    while (expected_results.size() != 0 || in_valid) @(posedge clk);
    drain_hold = 0;
    random_phase(50);
    wait_idle();

    write_reg(CfgAmpsPerCount, $urandom_range(1000, 400000));
    write_reg(CfgInvertA, 0);
    write_reg(CfgInvertB, 0);
    random_phase(60);
    wait_idle();

    if (mismatches == 0) $display("phase_current_to_signed_magnitude regression: pass");
    else $display("phase_current_to_signed_magnitude regression: fail");
    $finish;
  end
endmodule

### sim.f
rtl/pcsm_pkg.sv
rtl/phase_current_to_signed_magnitude.sv
test/phase_current_to_signed_magnitude_tb.sv
